[rtl/mbm_pkg.sv]
// Shared types and constants for the multicart bank mapper.
// Holds the command codes, the queue entry and result layouts and the decode constants.
// No dependencies.
package mbm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PRG   = 2'd1,
    CMD_CHR   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_OUTER,
    OP_BANK_SEL,
    OP_BANK_DATA,
    OP_FWD,
    OP_PRG,
    OP_ZERO,
    OP_CHR,
    OP_RD_PORT,
    OP_RD_EXT
  } op_t;

  // Outer register select, taken from address bits 1:0 of a 5xxx write
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_PRG    = 2'd1;
  localparam logic [1:0] REG_CHR    = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [15:0] PORT_LO        = 16'h5000;
  localparam logic [15:0] PORT_HI        = 16'h5FFF;
  localparam logic [15:0] BANK_DEC_MASK  = 16'hE001;
  localparam logic [15:0] BANK_SEL_ADDR  = 16'h8000;
  localparam logic [15:0] BANK_DATA_ADDR = 16'h8001;

  localparam logic [7:0] PRG_FIXED_LO = 8'hFE;
  localparam logic [7:0] PRG_FIXED_HI = 8'hFF;

  localparam logic [7:0] BANK_RESET [0:7] = '{8'd0, 8'd2, 8'd4, 8'd5,
                                               8'd6, 8'd7, 8'd0, 8'd0};

  typedef struct packed {
    op_t        op;
    logic [2:0] slot;   // prg slot, chr slot or outer register index
    logic [7:0] data;   // write data, or open bus for port reads
  } cmd_t;

  typedef struct packed {
    logic [6:0]  prg_bank;
    logic [10:0] chr_bank;
    logic        mirror_valid;
    logic        mirror_horizontal;
    logic [7:0]  read_data;
    logic        forwarded_to_base;
    logic        read_external;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/mbm_fifo.sv]
// Small first-word-fall-through queue used between the mapper stages.
// Depends on mbm_pkg for the status struct.
module mbm_fifo
  import mbm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/mbm_front.sv]
// Front end: decodes each bus request into an operation and queues it.
// Depends on mbm_pkg and mbm_fifo.
module mbm_front
  import mbm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  open_bus,
  output logic        full,
  input  logic        cmd_pop,
  output cmd_t        cmd,
  output logic        cmd_valid
);

  cmd_t    dec;
  q_stat_t stat;
  logic    in_port;

  assign in_port = (address >= PORT_LO) && (address <= PORT_HI);

  always_comb begin
    dec.op   = OP_NOP;
    dec.slot = '0;
    dec.data = write_data;
    unique case (cmd_code_t'(command))
      CMD_WRITE: begin
        if (address[15]) begin
          unique case (address & BANK_DEC_MASK)
            BANK_SEL_ADDR:  dec.op = OP_BANK_SEL;
            BANK_DATA_ADDR: dec.op = OP_BANK_DATA;
            default:        dec.op = OP_FWD;
          endcase
        end else if (in_port && address[1:0] != REG_UNUSED) begin
          dec.op   = OP_OUTER;
          dec.slot = {1'b0, address[1:0]};
        end
      end
      CMD_PRG: begin
        dec.op   = address[15] ? OP_PRG : OP_ZERO;
        dec.slot = {1'b0, address[14:13]};
      end
      CMD_CHR: begin
        dec.op   = OP_CHR;
        dec.slot = address[12:10];
      end
      CMD_READ: begin
        dec.op   = in_port ? OP_RD_PORT : OP_RD_EXT;
        dec.data = open_bus;
      end
      default: dec.op = OP_NOP;
    endcase
  end

  mbm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (dec),
    .pop     (cmd_pop),
    .rd_data (cmd),
    .stat    (stat)
  );

  assign full      = stat.full;
  assign cmd_valid = ~stat.empty;

endmodule

[rtl/mbm_back.sv]
// Back end: holds the mapper registers, carries out queued operations
// and forms one result per operation. Depends on mbm_pkg.
module mbm_back
  import mbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  input  logic       res_full,
  output logic       go,
  output res_t       res
);

  logic [7:0] om_r, om_nxt;
  logic [5:0] pob_r, pob_nxt;
  logic [7:0] cob_r, cob_nxt;
  logic [7:0] bs_r, bs_nxt;
  logic [7:0] bank_r [0:7];
  logic [7:0] bank_nxt [0:7];
  logic [2:0] latch_r, latch_nxt;
  logic [1:0] dip_r;

  logic [1:0]  prg_slot;
  logic [6:0]  prg_mask, prg_val, prg_out;
  logic [7:0]  prg_sel;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_mask, chr_sel, cn_mask, cn_base;
  logic [10:0] chr_out;
  logic        cnrom_now, cnrom_nxt;

  assign go        = cmd_valid & ~res_full;
  assign cnrom_now = om_r[2] & om_r[1];

  // State update
  always_comb begin
    om_nxt    = om_r;
    pob_nxt   = pob_r;
    cob_nxt   = cob_r;
    bs_nxt    = bs_r;
    latch_nxt = latch_r;
    for (int i = 0; i < 8; i++) begin
      bank_nxt[i] = bank_r[i];
    end
    if (go) begin
      unique case (cmd.op)
        OP_OUTER: begin
          if (!om_r[7]) begin
            unique case (cmd.slot[1:0])
              REG_MODE: om_nxt  = cmd.data;
              REG_PRG:  pob_nxt = cmd.data[5:0];
              REG_CHR:  cob_nxt = cmd.data;
              default:  om_nxt  = om_r;
            endcase
          end
        end
        OP_BANK_SEL, OP_BANK_DATA, OP_FWD: begin
          // the latch loads on every high write in CNROM modes, before decode
          if (cnrom_now) begin
            latch_nxt = cmd.data[2:0];
          end
          if (cmd.op == OP_BANK_SEL) begin
            bs_nxt = cmd.data;
          end
          if (cmd.op == OP_BANK_DATA) begin
            bank_nxt[bs_r[2:0]] = cmd.data;
          end
        end
        default: om_nxt = om_r;
      endcase
    end
  end

  // PRG translation
  always_comb begin
    prg_slot = cmd.slot[1:0];
    if (bs_r[6] && !prg_slot[0]) begin
      prg_slot = prg_slot ^ 2'b10;
    end
    unique case (prg_slot)
      2'd0:    prg_sel = bank_r[6];
      2'd1:    prg_sel = bank_r[7];
      2'd2:    prg_sel = PRG_FIXED_LO;
      default: prg_sel = PRG_FIXED_HI;
    endcase
    prg_mask = om_r[1] ? 7'h0F : 7'h1F;
    prg_val  = ({pob_r, 1'b0} & ~prg_mask) | (prg_sel[6:0] & prg_mask);
    if (!om_r[2]) begin
      prg_out = prg_val;
    end else if (om_r[1:0] == 2'd0) begin
      prg_out = {pob_r, cmd.slot[0]};
    end else begin
      prg_out = {pob_r[5:1], cmd.slot[1:0]};
    end
  end

  // CHR translation
  always_comb begin
    chr_slot = cmd.slot ^ {bs_r[7], 2'b00};
    unique case (chr_slot)
      3'd0:    chr_sel = {bank_r[0][7:1], 1'b0};
      3'd1:    chr_sel = {bank_r[0][7:1], 1'b1};
      3'd2:    chr_sel = {bank_r[1][7:1], 1'b0};
      3'd3:    chr_sel = {bank_r[1][7:1], 1'b1};
      3'd4:    chr_sel = bank_r[2];
      3'd5:    chr_sel = bank_r[3];
      3'd6:    chr_sel = bank_r[4];
      default: chr_sel = bank_r[5];
    endcase
    chr_mask = om_r[0] ? 8'h7F : 8'hFF;
    cn_mask  = om_r[0] ? 8'h03 : 8'h01;
    cn_base  = (cob_r & ~cn_mask) | ({5'd0, latch_r} & cn_mask);
    if (!om_r[2]) begin
      chr_out = ({cob_r, 3'd0} & ~{3'd0, chr_mask}) | {3'd0, chr_sel & chr_mask};
    end else if (!om_r[1]) begin
      chr_out = {cob_r, cmd.slot};
    end else begin
      chr_out = {cn_base, cmd.slot};
    end
  end

  // Result; mirroring reflects the state after this operation
  assign cnrom_nxt = om_nxt[2] & om_nxt[1];

  always_comb begin
    res                   = '0;
    res.mirror_valid      = cnrom_nxt;
    res.mirror_horizontal = cnrom_nxt & latch_nxt[2];
    case (cmd.op)
      OP_PRG:     res.prg_bank          = prg_out;
      OP_CHR:     res.chr_bank          = chr_out;
      OP_RD_PORT: res.read_data         = {cmd.data[7:2], dip_r};
      OP_RD_EXT:  res.read_external     = 1'b1;
      OP_FWD:     res.forwarded_to_base = 1'b1;
      default:    res.prg_bank          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      om_r    <= '0;
      pob_r   <= '0;
      cob_r   <= '0;
      bs_r    <= '0;
      latch_r <= '0;
      dip_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= BANK_RESET[i];
      end
    end else begin
      om_r    <= om_nxt;
      pob_r   <= pob_nxt;
      cob_r   <= cob_nxt;
      bs_r    <= bs_nxt;
      latch_r <= latch_nxt;
      if (cfg_wr_en) begin
        dip_r <= cfg_wr_data;
      end
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= bank_nxt[i];
      end
    end
  end

endmodule

[rtl/multicart_bank_mapper.sv]
// Multicart bank mapper built around an MMC3-style bank core.
// Channels: requests enter through push/full (command, address, write data,
// open bus); one result per request leaves through empty/pop, oldest first.
// Configuration: cfg_wr_en/cfg_wr_data write the two DIP bits at once.
// A request accepted from push is decoded into the command queue; the back end
// carries it out from the queue head into the result queue, whose head drives
// the result ports, and empty falls once that result is queued.
// Throughput: one request per cycle while full is low; the back end executes
// one queued operation per cycle while the result queue is not full.
// Reset (synchronous, rst_n low): both queues empty, outer registers, bank
// select and latch cleared, bank registers at 0,2,4,5,6,7,0,0, DIP bits 0.
// When the receiver stalls, results collect in the result queue; once it is
// full the back end holds, the command queue fills and full rises.
// Depends on mbm_pkg, mbm_front, mbm_back and mbm_fifo.
module multicart_bank_mapper
  import mbm_pkg::*;
#(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_open_bus,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  out_prg_bank,
  output logic [10:0] out_chr_bank,
  output logic        out_mirror_valid,
  output logic        out_mirror_horizontal,
  output logic [7:0]  out_read_data,
  output logic        out_forwarded_to_base,
  output logic        out_read_external
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    go;
  res_t    res, res_head;
  q_stat_t res_stat;

  mbm_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .command    (in_command),
    .address    (in_address),
    .write_data (in_write_data),
    .open_bus   (in_open_bus),
    .full       (full),
    .cmd_pop    (go),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid)
  );

  mbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .res_full    (res_stat.full),
    .go          (go),
    .res         (res)
  );

  mbm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (go),
    .wr_data (res),
    .pop     (pop),
    .rd_data (res_head),
    .stat    (res_stat)
  );

  assign empty                 = res_stat.empty;
  assign out_prg_bank          = res_head.prg_bank;
  assign out_chr_bank          = res_head.chr_bank;
  assign out_mirror_valid      = res_head.mirror_valid;
  assign out_mirror_horizontal = res_head.mirror_horizontal;
  assign out_read_data         = res_head.read_data;
  assign out_forwarded_to_base = res_head.forwarded_to_base;
  assign out_read_external     = res_head.read_external;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_mirror_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_mirror_horizontal) |-> out_mirror_valid)
    else $error("horizontal mirroring reported outside CNROM modes");

  a_ext_read : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_read_external) |->
      (out_read_data == 8'd0 && !out_forwarded_to_base && out_prg_bank == 7'd0))
    else $error("external read carries local data");

  a_no_result_without_op : assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !cmd_valid) |=> empty)
    else $error("result appeared with no queued operation");

endmodule
